// ===== rtl/assert_macros.svh =====
// Assertion macros used by the blit RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/mab_pkg.sv =====
// Types, constants and helper functions of the masked alpha blit.
package mab_pkg;

  localparam int unsigned MaxDim       = 4096;
  localparam int unsigned ShadowOffset = 3;
  localparam int unsigned CoordW       = 13;
  localparam int unsigned SizeW        = 13;
  localparam int unsigned CntW         = 12;
  localparam int unsigned PosW         = 15;
  localparam int unsigned AddrW        = 24;
  localparam int unsigned PixW         = 32;
  localparam int unsigned ColorW       = 24;
  localparam int unsigned CfgIdxW      = 4;
  localparam int unsigned CfgDataW     = 32;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_POS_X       = 4'd0,
    CFG_POS_Y       = 4'd1,
    CFG_DEST_WIDTH  = 4'd2,
    CFG_DEST_HEIGHT = 4'd3,
    CFG_MASK_WIDTH  = 4'd4,
    CFG_MASK_HEIGHT = 4'd5,
    CFG_FILL_COLOR  = 4'd6,
    CFG_SHADOW_PASS = 4'd7
  } cfg_idx_e;

  // Item held in the input register
  typedef struct packed {
    logic [7:0]             alpha;
    logic [PixW-1:0]        pixel;
    logic signed [PosW-1:0] x;
    logic signed [PosW-1:0] y;
    logic                   last;
  } stage_t;

  // Exact truncating divide by 255 for values up to 255*255
  function automatic logic [7:0] div255(input logic [15:0] v);
    logic [16:0] t;
    t = {1'b0, v} + 17'd1 + {9'd0, v[15:8]};
    return t[15:8];
  endfunction

  // Blend one channel: (src*a + dst*(255-a)) / 255
  function automatic logic [7:0] blend_chan(input logic [7:0] src, input logic [7:0] dst,
                                            input logic [7:0] a);
    logic [15:0] s;
    s = (16'(src) * 16'(a)) + (16'(dst) * 16'(8'hFF - a));
    return div255(s);
  endfunction

  // Last counter value for a mask size: zero counts as one, cap at the counter span
  function automatic logic [CntW-1:0] mask_last(input logic [SizeW-1:0] v);
    logic [SizeW-1:0] m;
    if (v == '0) begin
      m = '0;
    end else if (v > SizeW'(1 << CntW)) begin
      m = SizeW'((1 << CntW) - 1);
    end else begin
      m = v - SizeW'(1);
    end
    return m[CntW-1:0];
  endfunction

  // Destination size: zero counts as one, cap at MaxDim
  function automatic logic [SizeW-1:0] dest_clamp(input logic [SizeW-1:0] v);
    logic [SizeW-1:0] m;
    if (v == '0) begin
      m = SizeW'(1);
    end else if (v > SizeW'(MaxDim)) begin
      m = SizeW'(MaxDim);
    end else begin
      m = v;
    end
    return m;
  endfunction

endpackage

// ===== rtl/masked_alpha_blit_with_clipping.sv =====
// Masked solid-color alpha blit with destination clipping, two register stages.
//
//  channel | signals                                        | role
//  --------+------------------------------------------------+---------------------------
//  in      | in_valid_i, in_ready_o, mask_alpha_i,          | mask byte + dest pixel
//          | dest_pixel_i                                   |
//  out     | out_valid_o, out_ready_i, write_enable_o,      | write strobe, address,
//          | dest_address_o, out_pixel_o, last_o            | blended pixel, end of pass
//  cfg     | cfg_valid_i, cfg_ready_o, cfg_index_i,         | register writes, always ready
//          | cfg_data_i                                     |
//
// One item per clock while the output is not stalled; a result passes through the input
// register (position add) and then the result register (multiply for address, blend
// multipliers and divide by 255).
// Reset clears the mask counters and both valid flags and sets the configuration registers to their defaults.
// A stalled output holds its result; the input register keeps accepting while the
// result register is free or being drained.
module masked_alpha_blit_with_clipping (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [7:0]                      mask_alpha_i,
  input  logic [mab_pkg::PixW-1:0]        dest_pixel_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            write_enable_o,
  output logic [mab_pkg::AddrW-1:0]       dest_address_o,
  output logic [mab_pkg::PixW-1:0]        out_pixel_o,
  output logic                            last_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [mab_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [mab_pkg::CfgDataW-1:0]    cfg_data_i
);
  import mab_pkg::*;

  `include "assert_macros.svh"

  // Configuration registers
  logic [CoordW-1:0] pos_x_q, pos_y_q;
  logic [SizeW-1:0]  dest_w_q, dest_h_q, mask_w_q, mask_h_q;
  logic [ColorW-1:0] fill_q;
  logic              shadow_q;

  // Mask counters
  logic [CntW-1:0] col_q, col_d, row_q, row_d;

  // Pipeline
  stage_t s1_q, s1_d;
  logic   s1_valid_q;
  logic   s2_adv, in_xfer;

  logic              we_d, last_d;
  logic [AddrW-1:0]  addr_d;
  logic [PixW-1:0]   pix_d;

  assign cfg_ready_o = 1'b1;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q  <= '0;
      pos_y_q  <= '0;
      dest_w_q <= SizeW'(1);
      dest_h_q <= SizeW'(1);
      mask_w_q <= SizeW'(1);
      mask_h_q <= SizeW'(1);
      fill_q   <= '0;
      shadow_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_POS_X:       pos_x_q  <= cfg_data_i[CoordW-1:0];
        CFG_POS_Y:       pos_y_q  <= cfg_data_i[CoordW-1:0];
        CFG_DEST_WIDTH:  dest_w_q <= cfg_data_i[SizeW-1:0];
        CFG_DEST_HEIGHT: dest_h_q <= cfg_data_i[SizeW-1:0];
        CFG_MASK_WIDTH:  mask_w_q <= cfg_data_i[SizeW-1:0];
        CFG_MASK_HEIGHT: mask_h_q <= cfg_data_i[SizeW-1:0];
        CFG_FILL_COLOR:  fill_q   <= cfg_data_i[ColorW-1:0];
        CFG_SHADOW_PASS: shadow_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Handshake: result register frees when empty or drained
  assign s2_adv     = !out_valid_o || out_ready_i;
  assign in_ready_o = !s1_valid_q || s2_adv;
  assign in_xfer    = in_valid_i && in_ready_o;

  // Place the byte and advance the raster counters
  always_comb begin
    logic                   row_end, col_end;
    logic signed [PosW-1:0] off;
    row_end = col_q >= mask_last(mask_w_q);
    col_end = row_q >= mask_last(mask_h_q);
    off     = shadow_q ? PosW'(ShadowOffset) : '0;

    s1_d.alpha = mask_alpha_i;
    s1_d.pixel = dest_pixel_i;
    s1_d.x     = $signed({{(PosW-CoordW){pos_x_q[CoordW-1]}}, pos_x_q})
               + $signed({{(PosW-CntW){1'b0}}, col_q}) + off;
    s1_d.y     = $signed({{(PosW-CoordW){pos_y_q[CoordW-1]}}, pos_y_q})
               + $signed({{(PosW-CntW){1'b0}}, row_q}) + off;
    s1_d.last  = row_end && col_end;

    if (row_end) begin
      col_d = '0;
      row_d = col_end ? '0 : row_q + CntW'(1);
    end else begin
      col_d = col_q + CntW'(1);
      row_d = row_q;
    end
  end

  // Hold counters and the input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        col_q <= col_d;
        row_q <= row_d;
      end
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_q <= s1_d;
    end
  end

  // Clip, address and blend
  always_comb begin
    logic [SizeW-1:0]   dw, dh;
    logic               in_frame;
    logic [2*SizeW-1:0] prod;
    logic [7:0]         a, oa, orr, og, ob;
    dw       = dest_clamp(dest_w_q);
    dh       = dest_clamp(dest_h_q);
    in_frame = !s1_q.x[PosW-1] && !s1_q.y[PosW-1]
            && (s1_q.x[PosW-2:0] < {{(PosW-1-SizeW){1'b0}}, dw})
            && (s1_q.y[PosW-2:0] < {{(PosW-1-SizeW){1'b0}}, dh});
    a        = s1_q.alpha;
    we_d     = in_frame && (a != 8'd0);
    last_d   = s1_q.last;

    prod   = {{(2*SizeW-CntW){1'b0}}, s1_q.y[CntW-1:0]} * {{SizeW{1'b0}}, dw};
    oa     = a + div255(16'(s1_q.pixel[31:24]) * 16'(8'hFF - a));
    orr    = blend_chan(fill_q[23:16], s1_q.pixel[23:16], a);
    og     = blend_chan(fill_q[15:8],  s1_q.pixel[15:8],  a);
    ob     = blend_chan(fill_q[7:0],   s1_q.pixel[7:0],   a);

    if (we_d) begin
      addr_d = prod[AddrW-1:0] + {{(AddrW-CoordW){1'b0}}, s1_q.x[CoordW-1:0]};
      pix_d  = {oa, orr, og, ob};
    end else begin
      addr_d = '0;
      pix_d  = '0;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (s2_adv) begin
      out_valid_o <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_adv && s1_valid_q) begin
      write_enable_o <= we_d;
      dest_address_o <= addr_d;
      out_pixel_o    <= pix_d;
      last_o         <= last_d;
    end
  end

  // Checks
  `ASSERT_IMPL(a_zero_when_skipped, out_valid_o && !write_enable_o,
               dest_address_o == '0 && out_pixel_o == '0, "skipped result not zero")
  `ASSERT_IMPL(a_written_alpha, out_valid_o && write_enable_o,
               out_pixel_o[31:24] != 8'd0, "written pixel has zero alpha")
  `ASSERT_NEXT(a_wrap_after_last, in_xfer && s1_d.last,
               col_q == '0 && row_q == '0, "counters did not wrap after last byte")
  `ASSERT_IMPL(a_stall_cause, !in_ready_o,
               s1_valid_q && out_valid_o && !out_ready_i, "input stalled without cause")

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the masked alpha blit with clipping.
`timescale 1ns / 1ps

module testbench;
  import mab_pkg::*;

  localparam int unsigned ClkPeriod    = 10;
  localparam int unsigned ResetCycles  = 5;
  localparam int unsigned CycleLimit   = 1000000;
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned RandomItems  = 1350;
  localparam int unsigned FullCover    = 255;
  localparam int unsigned CfgIdxCount  = 8;

  typedef enum logic [1:0] {
    OP_PIXEL,
    OP_REG_WRITE,
    OP_DRAIN
  } blit_op_e;

  typedef struct {
    blit_op_e             kind;
    logic [CfgIdxW-1:0]   idx;
    logic [CfgDataW-1:0]  data;
    logic [7:0]           alpha;
    logic [PixW-1:0]      pixel;
  } blit_op_t;

  typedef struct packed {
    logic             wr_en;
    logic [AddrW-1:0] addr;
    logic [PixW-1:0]  pixel;
    logic             last;
  } pixel_write_t;

  // DUT signals
  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                in_valid   = 1'b0;
  logic                in_ready;
  logic [7:0]          mask_alpha = '0;
  logic [PixW-1:0]     dest_pixel = '0;
  logic                out_valid;
  logic                out_ready  = 1'b0;
  logic                wr_en;
  logic [AddrW-1:0]    addr;
  logic [PixW-1:0]     out_pixel;
  logic                last;
  logic                cfg_valid  = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index  = '0;
  logic [CfgDataW-1:0] cfg_data   = '0;

  // Register copy and raster counters of the predictor, at their reset values
  logic [SizeW-1:0]  frame_pos_x  = '0;
  logic [SizeW-1:0]  frame_pos_y  = '0;
  logic [SizeW-1:0]  frame_w      = SizeW'(1);
  logic [SizeW-1:0]  frame_h      = SizeW'(1);
  logic [SizeW-1:0]  glyph_w      = SizeW'(1);
  logic [SizeW-1:0]  glyph_h      = SizeW'(1);
  logic [ColorW-1:0] fill         = '0;
  logic              frame_shadow = 1'b0;
  logic [CntW-1:0]   col_cnt      = '0;
  logic [CntW-1:0]   row_cnt      = '0;

  blit_op_t     blit_ops[$];
  pixel_write_t expected_writes[$];

  logic        in_taken   = 1'b0;
  logic        cfg_taken  = 1'b0;
  logic        calm       = 1'b0;
  int unsigned calm_left  = 0;
  int unsigned send_gap   = 0;
  int unsigned ready_hold = 0;
  int unsigned settle_cnt = 0;
  int unsigned cycle_cnt  = 0;
  int unsigned fail_cnt   = 0;

  masked_alpha_blit_with_clipping u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .mask_alpha_i   (mask_alpha),
    .dest_pixel_i   (dest_pixel),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .write_enable_o (wr_en),
    .dest_address_o (addr),
    .out_pixel_o    (out_pixel),
    .last_o         (last),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  always #(ClkPeriod / 2) clk = ~clk;

  // Size as the block sees it: zero counts as one, cap at top
  function automatic int fit_size(input logic [SizeW-1:0] v, input int top);
    if (v == '0) return 1;
    return (int'(v) > top) ? top : int'(v);
  endfunction

  function automatic int unsigned chan_mix(input int unsigned src, input int unsigned dst,
                                           input int unsigned a);
    return (src * a + dst * (FullCover - a)) / FullCover;
  endfunction

  // Compute the write for one mask byte and advance the raster counters
  function automatic pixel_write_t predict_write(input logic [7:0] alpha,
                                                 input logic [PixW-1:0] pixel);
    pixel_write_t w;
    int dw, dh, mw, mh, off, x, y;
    int unsigned a, oa;
    logic row_end, col_end;
    dw  = fit_size(frame_w, MaxDim);
    dh  = fit_size(frame_h, MaxDim);
    mw  = fit_size(glyph_w, 1 << CntW);
    mh  = fit_size(glyph_h, 1 << CntW);
    off = frame_shadow ? int'(ShadowOffset) : 0;
    x   = int'($signed(frame_pos_x)) + int'(col_cnt) + off;
    y   = int'($signed(frame_pos_y)) + int'(row_cnt) + off;
    a   = 32'(alpha);
    w   = '0;
    w.wr_en = (x >= 0) && (y >= 0) && (x < dw) && (y < dh) && (alpha != 8'd0);
    row_end = int'(col_cnt) >= mw - 1;
    col_end = int'(row_cnt) >= mh - 1;
    w.last  = row_end && col_end;
    if (w.wr_en) begin
      oa = a + (int'(pixel[31:24]) * (FullCover - a)) / FullCover;
      w.pixel = {8'(oa),
                 8'(chan_mix(32'(fill[23:16]), 32'(pixel[23:16]), a)),
                 8'(chan_mix(32'(fill[15:8]), 32'(pixel[15:8]), a)),
                 8'(chan_mix(32'(fill[7:0]), 32'(pixel[7:0]), a))};
      w.addr = AddrW'(y * dw + x);
    end
    // Wrap the column at the row end, the row at the mask end
    if (row_end) begin
      col_cnt = '0;
      row_cnt = col_end ? '0 : row_cnt + 1'b1;
    end else begin
      col_cnt = col_cnt + 1'b1;
    end
    return w;
  endfunction

  // Idle length: mostly none or short, a few long, none at all in calm stretches
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Size picked among the clamping corners, or else a plain in-range size
  function automatic int odd_size();
    case ($urandom_range(0, 4))
      0: return 0;
      1: return 1;
      2: return 4096;
      3: return $urandom_range(4097, 8191);
      default: return $urandom_range(2, 4095);
    endcase
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_cnt++;
    end
  endtask

  task automatic add_pixel(input logic [7:0] alpha, input logic [PixW-1:0] pixel);
    blit_ops.push_back('{OP_PIXEL, '0, '0, alpha, pixel});
  endtask

  task automatic drain_pipe();
    blit_ops.push_back('{OP_DRAIN, '0, '0, '0, '0});
  endtask

  // Queue a register write, sometimes with junk above the register width
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input int value);
    logic [CfgDataW-1:0] keep;
    logic [CfgDataW-1:0] junk;
    int unsigned w;
    case (cfg_idx_e'(idx))
      CFG_FILL_COLOR:  w = ColorW;
      CFG_SHADOW_PASS: w = 1;
      default:         w = SizeW;
    endcase
    keep = (CfgDataW'(1) << w) - 1'b1;
    junk = $urandom_range(0, 1) ? ($urandom() & ~keep) : '0;
    blit_ops.push_back('{OP_REG_WRITE, idx, (CfgDataW'(value) & keep) | junk, '0, '0});
  endtask

  task automatic set_frame(input int px, input int py, input int dw, input int dh,
                           input int mw, input int mh, input int color, input int shadow);
    drain_pipe();
    write_reg(CFG_POS_X, px);
    write_reg(CFG_POS_Y, py);
    write_reg(CFG_DEST_WIDTH, dw);
    write_reg(CFG_DEST_HEIGHT, dh);
    write_reg(CFG_MASK_WIDTH, mw);
    write_reg(CFG_MASK_HEIGHT, mh);
    write_reg(CFG_FILL_COLOR, color);
    write_reg(CFG_SHADOW_PASS, shadow);
  endtask

  // Cycle count and calm-stretch selection
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (calm_left == 0) begin
      calm      <= ($urandom_range(0, 3) == 0);
      calm_left <= $urandom_range(50, 300);
    end else begin
      calm_left <= calm_left - 1;
    end
  end

  // Driver: issue pixels and register writes from the op queue, waiting at drain marks
  always @(negedge clk) begin
    blit_op_t op;
    logic nxt_in, nxt_cfg;
    nxt_in  = in_valid && !in_taken;
    nxt_cfg = cfg_valid && !cfg_taken;
    if (rst_n && !nxt_in && !nxt_cfg) begin
      if (send_gap > 0) begin
        send_gap--;
      end else if (blit_ops.size() > 0) begin
        case (blit_ops[0].kind)
          OP_PIXEL: begin
            op = blit_ops.pop_front();
            mask_alpha <= op.alpha;
            dest_pixel <= op.pixel;
            nxt_in   = 1'b1;
            send_gap = pick_gap();
          end
          OP_REG_WRITE: begin
            op = blit_ops.pop_front();
            cfg_index <= op.idx;
            cfg_data  <= op.data;
            nxt_cfg = 1'b1;
          end
          default: begin
            // Hold until every write is checked, then let the pipe settle
            if (expected_writes.size() != 0) begin
              settle_cnt = 0;
            end else if (settle_cnt < SettleCycles) begin
              settle_cnt++;
            end else begin
              settle_cnt = 0;
              blit_ops.delete(0);
            end
          end
        endcase
      end
    end
    in_valid  <= nxt_in;
    cfg_valid <= nxt_cfg;
  end

  // Result sink: random backpressure
  always @(negedge clk) begin
    if (rst_n) begin
      if (ready_hold > 0) begin
        ready_hold--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        ready_hold = pick_gap();
      end
    end
  end

  // Monitor: check results, track register writes, predict accepted pixels
  always @(posedge clk) begin
    pixel_write_t got, want;
    if (rst_n) begin
      in_taken  <= in_valid && in_ready;
      cfg_taken <= cfg_valid && cfg_ready;
      if (out_valid && out_ready) begin
        got = '{wr_en, addr, out_pixel, last};
        if (expected_writes.size() == 0) begin
          $error("unexpected result transfer: we=%0b addr=0x%0h pixel=0x%0h last=%0b",
                 got.wr_en, got.addr, got.pixel, got.last);
          fail_cnt++;
        end else begin
          want = expected_writes.pop_front();
          check_field("write_enable", 32'(want.wr_en), 32'(got.wr_en));
          check_field("dest_address", 32'(want.addr), 32'(got.addr));
          check_field("out_pixel", want.pixel, got.pixel);
          check_field("last", 32'(want.last), 32'(got.last));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_e'(cfg_index))
          CFG_POS_X:       frame_pos_x  = cfg_data[SizeW-1:0];
          CFG_POS_Y:       frame_pos_y  = cfg_data[SizeW-1:0];
          CFG_DEST_WIDTH:  frame_w      = cfg_data[SizeW-1:0];
          CFG_DEST_HEIGHT: frame_h      = cfg_data[SizeW-1:0];
          CFG_MASK_WIDTH:  glyph_w      = cfg_data[SizeW-1:0];
          CFG_MASK_HEIGHT: glyph_h      = cfg_data[SizeW-1:0];
          CFG_FILL_COLOR:  fill         = cfg_data[ColorW-1:0];
          CFG_SHADOW_PASS: frame_shadow = cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        expected_writes.push_back(predict_write(mask_alpha, dest_pixel));
      end
    end
  end

  // Stimulus plan, reset and end of run
  initial begin
    int mw, mh, dw, dh, px, py, n, r, k, done_items;
    logic [7:0] alpha;

    // Reset defaults: 1x1 frame at the origin, black fill
    add_pixel(8'd0, 32'hFFFF_FFFF);
    add_pixel(8'hFF, 32'h1234_5678);
    add_pixel(8'd1, 32'h0000_0000);
    // One full 3x2 pass inside a 4x3 frame
    set_frame(0, 0, 4, 3, 3, 2, 24'hFF8040, 0);
    add_pixel(8'hFF, 32'h0000_0000);
    add_pixel(8'h80, 32'hFFFF_FFFF);
    add_pixel(8'd0, 32'hA5A5_A5A5);
    add_pixel(8'd1, 32'h5A5A_5A5A);
    add_pixel(8'hC8, 32'hFF00_00FF);
    add_pixel(8'h4D, 32'h00FF_FF00);
    // Every register at an extreme: zero and oversized sizes, mask off the frame
    set_frame(-4096, 4095, 0, 8191, 0, 8191, 24'hFFFFFF, 1);
    add_pixel(8'hFF, 32'hFFFF_FFFF);
    add_pixel(8'h01, 32'h8000_0001);
    add_pixel(8'h7F, 32'h7FFF_FFFE);
    // Shadow offset cancels a negative position; counters start past the end
    set_frame(-3, -3, 4096, 4096, 2, 2, 0, 1);
    add_pixel(8'hFF, 32'hFFFF_FFFF);
    add_pixel(8'd1, 32'h0000_0000);
    add_pixel(8'hFE, 32'hFFFF_FFFF);
    add_pixel(8'h80, 32'h0101_0101);
    // Bottom right corner of the largest frame, then pushed off it by the shadow
    set_frame(4095, 4095, 4096, 4096, 1, 1, 24'h00FF00, 0);
    add_pixel(8'hFF, 32'hFFFF_FFFF);
    add_pixel(8'h40, 32'h0000_0000);
    add_pixel(8'hFF, 32'h1357_9BDF);
    drain_pipe();
    write_reg(CFG_SHADOW_PASS, 1);
    add_pixel(8'hFF, 32'hFFFF_FFFF);

    // Random frames: mostly whole passes, some shrunk mid-pass or at the corners
    mw = 1;
    mh = 1;
    done_items = 0;
    while (done_items < RandomItems) begin
      r = $urandom_range(0, 99);
      if (r < 15) begin
        drain_pipe();
        mw = $urandom_range(1, (mw > 16) ? 16 : mw);
        mh = $urandom_range(1, (mh > 8) ? 8 : mh);
        write_reg(CFG_MASK_WIDTH, mw);
        write_reg(CFG_MASK_HEIGHT, mh);
        write_reg(CFG_FILL_COLOR, $urandom());
        n = $urandom_range(1, 60);
      end else if (r < 88) begin
        mw = $urandom_range(1, 12);
        mh = $urandom_range(1, 6);
        dw = $urandom_range(1, 24);
        dh = $urandom_range(1, 16);
        px = int'($urandom_range(0, dw + mw + 6)) - mw - 3;
        py = int'($urandom_range(0, dh + mh + 6)) - mh - 3;
        set_frame(px, py, dw, dh, mw, mh, $urandom(), $urandom_range(0, 1));
        n = ($urandom_range(0, 6) == 0) ? $urandom_range(1, mw * mh * 2)
                                        : mw * mh * $urandom_range(1, 3);
      end else begin
        mw = odd_size();
        mh = odd_size();
        set_frame(int'($urandom_range(0, 8191)) - 4096, int'($urandom_range(0, 8191)) - 4096,
                  odd_size(), odd_size(), mw, mh, $urandom(), $urandom_range(0, 1));
        n = $urandom_range(1, 40);
      end
      if ($urandom_range(0, 9) == 0) begin
        write_reg(CfgIdxW'($urandom_range(CfgIdxCount, (1 << CfgIdxW) - 1)), $urandom());
      end
      for (k = 0; k < n; k++) begin
        case ($urandom_range(0, 7))
          0, 1:    alpha = 8'd0;
          2:       alpha = 8'hFF;
          3:       alpha = 8'd1;
          default: alpha = 8'($urandom_range(0, 255));
        endcase
        add_pixel(alpha, $urandom());
        // Occasionally stop sending until all results are back
        if (k == n / 2 && $urandom_range(0, 19) == 0) drain_pipe();
      end
      done_items += n;
    end

    // Hold reset, then release away from the sampling edge
    repeat (ResetCycles) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (blit_ops.size() != 0 || in_valid || cfg_valid) @(posedge clk);
    while (expected_writes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Timeout
  initial begin
    while (cycle_cnt < CycleLimit) @(posedge clk);
    $display("Verification failed");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/mab_pkg.sv
rtl/masked_alpha_blit_with_clipping.sv
test/testbench.sv
